// File: rtl/hcbd_pkg.sv
// Shared types, constants and character helpers for the HTTP chunked body decoder.
// No dependencies; imported by the interfaces' users and the top level.
package hcbd_pkg;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_SKIP1,
		PH_SKIP2,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		DG_NONE,
		DG_READING,
		DG_ENDED
	} digit_t;

	typedef enum logic [1:0] {
		PX_NOTHING,
		PX_LONE_ZERO,
		PX_CLOSED
	} prefix_t;

	localparam logic [1:0] ST_COMPLETE  = 2'd0;
	localparam logic [1:0] ST_BOUNDARY  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic [1:0] out_status;
	} res_t;

	function automatic hex_t hex_value(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			h.ok  = 1'b1;
			h.val = 4'(c[2:0] + 3'd1) + 4'd8;
		end
		return h;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

endpackage

// File: rtl/hcbd_ifs.sv
// Valid/ready channel interfaces for body words in and decoded words out.
// No dependencies.
interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, in_byte, in_last, input ready);
	modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic [1:0] out_status;

	modport source(output valid, out_byte, out_valid, out_last, out_status, input ready);
	modport sink(input valid, out_byte, out_valid, out_last, out_status, output ready);
endinterface

// File: rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder: passes chunk payload words, drops framing.
// A result is registered into the output buffer when its input word is accepted.
// Throughput: one input word per cycle; a two-entry output buffer keeps input
// open while one result waits. Stalls only when both buffer entries are full.
// Reset (arst_n low) returns the parser to the start of a size line, empty buffer.
// Depends on hcbd_pkg and hcbd_ifs.
module http_chunked_body_decoder
	import hcbd_pkg::*;
#(
	parameter int SIZE_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	hcbd_in_if.sink         din,
	hcbd_out_if.source      dout
);

	typedef struct packed {
		digit_t                 dg;
		prefix_t                px;
		logic [SIZE_BITS-1:0]   acc;
	} line_t;

	function automatic logic [SIZE_BITS-1:0] add_digit(input logic [SIZE_BITS-1:0] a,
		input logic [3:0] d);
		if (|a[SIZE_BITS-1 -: 4])
			return '1;
		return {a[SIZE_BITS-5:0], d};
	endfunction

	function automatic line_t feed(input logic [7:0] c, input line_t s);
		line_t r;
		hex_t  h;
		r = s;
		h = hex_value(c);
		unique case (s.dg)
			DG_NONE: begin
				if (!is_blank(c)) begin
					if (!h.ok) begin
						r.dg = DG_ENDED;
					end else begin
						r.acc = add_digit(s.acc, h.val);
						r.dg  = DG_READING;
						r.px  = (c == CH_ZERO) ? PX_LONE_ZERO : PX_CLOSED;
					end
				end
			end
			DG_READING: begin
				r.px = PX_CLOSED;
				if (!(s.px == PX_LONE_ZERO && (c == CH_X_LO || c == CH_X_UP))) begin
					if (!h.ok)
						r.dg = DG_ENDED;
					else
						r.acc = add_digit(s.acc, h.val);
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	phase_t               phase_q, phase_d;
	line_t                line_q, line_d, line_f1;
	logic [SIZE_BITS-1:0] left_q, left_d;
	logic                 cr_q, cr_d;

	logic [1:0] count_q;
	res_t       ent0_q, ent1_q;
	res_t       res;
	logic       accept, push, pop;

	assign din.ready = (count_q != 2'd2);
	assign accept    = din.valid && din.ready;
	assign pop       = dout.valid && dout.ready;

	always_comb begin
		phase_d = phase_q;
		line_d  = line_q;
		left_d  = left_q;
		cr_d    = cr_q;
		line_f1 = feed(CH_CR, line_q);
		res     = '0;
		unique case (phase_q)
			PH_SIZE: begin
				if (cr_q && din.in_byte == CH_LF) begin
					if (line_q.acc == '0) begin
						phase_d = PH_DONE;
					end else begin
						phase_d = PH_DATA;
						left_d  = line_q.acc;
					end
					line_d = '{dg: DG_NONE, px: PX_NOTHING, acc: '0};
					cr_d   = 1'b0;
				end else begin
					line_d = cr_q ? line_f1 : line_q;
					if (din.in_byte == CH_CR) begin
						cr_d = 1'b1;
					end else begin
						cr_d   = 1'b0;
						line_d = feed(din.in_byte, cr_q ? line_f1 : line_q);
					end
				end
			end
			PH_DATA: begin
				res.out_valid = 1'b1;
				res.out_byte  = din.in_byte;
				left_d        = left_q - SIZE_BITS'(1);
				if (left_q == SIZE_BITS'(1))
					phase_d = PH_SKIP1;
			end
			PH_SKIP1: phase_d = PH_SKIP2;
			PH_SKIP2: phase_d = PH_SIZE;
			default:  phase_d = PH_DONE;
		endcase
		if (din.in_last) begin
			res.out_last = 1'b1;
			priority if (phase_d == PH_DONE)
				res.out_status = ST_COMPLETE;
			else if (phase_d == PH_DATA)
				res.out_status = ST_TRUNCATED;
			else
				res.out_status = ST_BOUNDARY;
			phase_d = PH_SIZE;
			line_d  = '{dg: DG_NONE, px: PX_NOTHING, acc: '0};
			left_d  = '0;
			cr_d    = 1'b0;
		end
	end

	assign push = accept && (res.out_valid || res.out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			line_q  <= '{dg: DG_NONE, px: PX_NOTHING, acc: '0};
			left_q  <= '0;
			cr_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			line_q  <= line_d;
			left_q  <= left_d;
			cr_q    <= cr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && count_q == 2'd1)
				ent0_q <= res;
			else
				ent0_q <= ent1_q;
			if (push && count_q == 2'd2)
				ent1_q <= res;
		end else if (push) begin
			if (count_q == 2'd0)
				ent0_q <= res;
			else
				ent1_q <= res;
		end
	end

	assign dout.valid      = (count_q != 2'd0);
	assign dout.out_byte   = ent0_q.out_byte;
	assign dout.out_valid  = ent0_q.out_valid;
	assign dout.out_last   = ent0_q.out_last;
	assign dout.out_status = ent0_q.out_status;

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && din.in_last |=> phase_q == PH_SIZE && line_q.acc == '0 && !cr_q)
		else $error("parser state not cleared after final word");

	a_data_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != '0)
		else $error("data phase with no bytes left");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.out_last |-> dout.out_status == ST_COMPLETE)
		else $error("status set on a non-final result");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.out_valid |-> dout.out_byte == 8'd0)
		else $error("byte set on a result without payload");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push)
		else $error("output buffer overflow");

endmodule

// File: tb/sv/http_chunked_body_decoder_tb.sv
// Testbench for http_chunked_body_decoder: drives raw body words, predicts payload and status.
// Uses hcbd_pkg and the hcbd_in_if/hcbd_out_if channels; compares each decoded word in order.
module http_chunked_body_decoder_tb;
	import hcbd_pkg::*;

	localparam int SIZE_BITS = 32;
	localparam int ITEM_TARGET = 1150;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [63:0] SIZE_ALL_ONES = {64{1'b1}} >> (64 - SIZE_BITS);

	logic clk = 1'b0;
	logic arst_n;

	hcbd_in_if  body_ch ();
	hcbd_out_if payload_ch ();

	http_chunked_body_decoder #(
		.SIZE_BITS(SIZE_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (body_ch),
		.dout  (payload_ch)
	);

	always #5 clk = ~clk;

	// predictor state
	phase_t      pred_phase;
	logic [63:0] pred_size;
	logic [63:0] pred_left;
	digit_t      pred_digits;
	prefix_t     pred_prefix;
	logic        pred_cr;
	logic        pred_sat;

	res_t        decoded_q[$];
	res_t        got;
	res_t        want;
	res_t        next_res;
	logic [7:0]  body_q[$];

	int          error_count = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	bit          tx_idle_on = 1'b0;
	bit          rx_idle_on = 1'b0;
	int          rx_hold_cycles = 0;
	int          rx_stall_left = 0;

	function automatic int nibble_of(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66)
			return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46)
			return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic bit is_space_char(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void clear_predictor();
		pred_phase  = PH_SIZE;
		pred_size   = '0;
		pred_left   = '0;
		pred_digits = DG_NONE;
		pred_prefix = PX_NOTHING;
		pred_cr     = 1'b0;
		pred_sat    = 1'b0;
	endfunction

	function automatic void push_nibble(input logic [3:0] d);
		if (pred_sat)
			return;
		if (pred_size > (SIZE_ALL_ONES >> 4)) begin
			pred_sat  = 1'b1;
			pred_size = SIZE_ALL_ONES;
			return;
		end
		pred_size = (pred_size << 4) | 64'(d);
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		int d;
		d = nibble_of(c);
		if (pred_digits == DG_ENDED)
			return;
		if (pred_digits == DG_NONE) begin
			if (is_space_char(c))
				return;
			if (d < 0) begin
				pred_digits = DG_ENDED;
				return;
			end
			push_nibble(d[3:0]);
			pred_digits = DG_READING;
			pred_prefix = (c == CH_ZERO) ? PX_LONE_ZERO : PX_CLOSED;
			return;
		end
		if (pred_prefix == PX_LONE_ZERO && (c == CH_X_LO || c == CH_X_UP)) begin
			pred_prefix = PX_CLOSED;
			return;
		end
		pred_prefix = PX_CLOSED;
		if (d < 0)
			pred_digits = DG_ENDED;
		else
			push_nibble(d[3:0]);
	endfunction

	// one body word in, at most one decoded word out
	function automatic bit decode_word(input logic [7:0] c, input logic last, output res_t r);
		bit          emit;
		logic [1:0]  status;
		logic [63:0] line_size;
		emit   = 1'b0;
		status = ST_COMPLETE;
		case (pred_phase)
			PH_SIZE: begin
				if (pred_cr && c == CH_LF) begin
					line_size = pred_sat ? SIZE_ALL_ONES : pred_size;
					if (line_size == 0) begin
						pred_phase = PH_DONE;
					end else begin
						pred_phase = PH_DATA;
						pred_left  = line_size;
					end
					pred_size   = '0;
					pred_digits = DG_NONE;
					pred_prefix = PX_NOTHING;
					pred_cr     = 1'b0;
					pred_sat    = 1'b0;
				end else begin
					if (pred_cr) begin
						pred_cr = 1'b0;
						parse_char(CH_CR);
					end
					if (c == CH_CR)
						pred_cr = 1'b1;
					else
						parse_char(c);
				end
			end
			PH_DATA: begin
				emit      = 1'b1;
				pred_left = pred_left - 1;
				if (pred_left == 0)
					pred_phase = PH_SKIP1;
			end
			PH_SKIP1: pred_phase = PH_SKIP2;
			PH_SKIP2: pred_phase = PH_SIZE;
			default:  pred_phase = PH_DONE;
		endcase
		if (!emit && !last)
			return 1'b0;
		if (last) begin
			if (pred_phase == PH_DONE)
				status = ST_COMPLETE;
			else if (pred_phase == PH_DATA && pred_left != 0)
				status = ST_TRUNCATED;
			else
				status = ST_BOUNDARY;
			clear_predictor();
		end
		r.out_byte   = emit ? c : 8'h00;
		r.out_valid  = emit;
		r.out_last   = last;
		r.out_status = status;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned seen,
		input int unsigned wanted);
		$display("mismatch on decoded word %0d: %s got %0h want %0h",
			results_seen, what, seen, wanted);
		error_count++;
	endtask

	// output check first, then prediction of the word accepted at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (payload_ch.valid && payload_ch.ready) begin
				got.out_byte   = payload_ch.out_byte;
				got.out_valid  = payload_ch.out_valid;
				got.out_last   = payload_ch.out_last;
				got.out_status = payload_ch.out_status;
				if (decoded_q.size() == 0) begin
					report_mismatch("word with nothing pending", got.out_byte, 0);
				end else begin
					want = decoded_q.pop_front();
					if (got.out_byte !== want.out_byte)
						report_mismatch("out_byte", got.out_byte, want.out_byte);
					if (got.out_valid !== want.out_valid)
						report_mismatch("out_valid", got.out_valid, want.out_valid);
					if (got.out_last !== want.out_last)
						report_mismatch("out_last", got.out_last, want.out_last);
					if (got.out_status !== want.out_status)
						report_mismatch("out_status", got.out_status, want.out_status);
				end
				results_seen++;
			end
			if (body_ch.valid && body_ch.ready) begin
				if (decode_word(body_ch.in_byte, body_ch.in_last, next_res))
					decoded_q.push_back(next_res);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : receiver
		payload_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				payload_ch.ready <= 1'b0;
				rx_hold_cycles--;
			end else if (rx_stall_left > 0) begin
				payload_ch.ready <= 1'b0;
				rx_stall_left--;
			end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
				payload_ch.ready <= 1'b0;
				rx_stall_left = $urandom_range(0, 16);
			end else begin
				payload_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			body_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		body_ch.valid   <= 1'b1;
		body_ch.in_byte <= b;
		body_ch.in_last <= last;
		do
			@(posedge clk);
		while (!body_ch.ready);
		items_sent++;
	endtask

	task automatic send_body();
		for (int i = 0; i < body_q.size(); i++)
			send_word(body_q[i], i == body_q.size() - 1);
		body_q.delete();
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			body_q.push_back(s[i]);
	endtask

	task automatic add_crlf();
		body_q.push_back(CH_CR);
		body_q.push_back(CH_LF);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return CH_ZERO + 8'(n);
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] pick_payload();
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0:       return 8'h00;
				1:       return 8'hFF;
				2:       return CH_CR;
				default: return CH_LF;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_size_line(input logic [63:0] size);
		int nd;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 3))
					0:       body_q.push_back(CH_SPACE);
					1:       body_q.push_back(CH_TAB);
					2:       body_q.push_back(CH_CR);
					default: body_q.push_back(8'h0B);
				endcase
			end
		end
		if ($urandom_range(0, 3) == 0) begin
			body_q.push_back(CH_ZERO);
			body_q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
		end
		if ($urandom_range(0, 5) == 0)
			body_q.push_back(CH_ZERO);
		nd = 1;
		while (nd < 16 && (size >> (4 * nd)) != 0)
			nd++;
		for (int i = nd - 1; i >= 0; i--)
			body_q.push_back(hex_char(size[4 * i +: 4]));
		if ($urandom_range(0, 3) == 0) begin
			body_q.push_back(8'h3B);
			repeat ($urandom_range(1, 5))
				body_q.push_back(8'($urandom_range('h21, 'h7E)));
		end
		add_crlf();
	endtask

	// mostly proper bodies; some end early, overflow, or close on a bad size line
	task automatic build_body();
		int          keep;
		logic [63:0] size;
		repeat ($urandom_range(0, 3)) begin
			size = 64'(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12));
			add_size_line(size);
			repeat (size)
				body_q.push_back(pick_payload());
			if ($urandom_range(0, 7) == 0) begin
				body_q.push_back(pick_payload());
				body_q.push_back(pick_payload());
			end else begin
				add_crlf();
			end
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				add_size_line(0);
				add_crlf();
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 4))
						body_q.push_back(pick_payload());
			end
			6: begin
				size = $urandom_range(0, 1) ? SIZE_ALL_ONES : {32'($urandom), 32'($urandom)};
				if (size <= SIZE_ALL_ONES && size != SIZE_ALL_ONES)
					size = size | (SIZE_ALL_ONES + 1);
				add_size_line(size);
				repeat ($urandom_range(0, 3))
					body_q.push_back(pick_payload());
			end
			7: begin
				add_size_line(0);
				add_crlf();
				keep   = $urandom_range(1, body_q.size());
				body_q = body_q[0:keep - 1];
			end
			8: ;
			default: begin
				case ($urandom_range(0, 3))
					0:       add_text("+7");
					1:       add_text("-1");
					2:       add_text("0x");
					default: add_text("0X;z");
				endcase
				add_crlf();
			end
		endcase
		if (body_q.size() == 0)
			body_q.push_back(pick_payload());
	endtask

	task automatic test_directed_cases();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// lone CR before the digits and right after them; body ends on the data word
		body_q.push_back(CH_CR);
		add_text("1");
		body_q.push_back(CH_CR);
		add_text("5");
		add_crlf();
		body_q.push_back(8'h00);
		send_body();
		// prefix without digits gives size zero; trailing word dropped
		add_text("0x");
		add_crlf();
		body_q.push_back(8'hFF);
		send_body();
		// sign first means no digits
		add_text("-5");
		add_crlf();
		send_body();
		// size saturates, body ends on the LF of the size line
		add_text("FfFFFFFFF");
		add_crlf();
		send_body();
	endtask

	task automatic test_random_bodies();
		while (items_sent < 700) begin
			tx_idle_on = $urandom_range(0, 3) != 0;
			rx_idle_on = $urandom_range(0, 3) != 0;
			build_body();
			send_body();
		end
	endtask

	task automatic test_output_backpressure();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		add_size_line(48);
		repeat (48)
			body_q.push_back(pick_payload());
		add_crlf();
		add_size_line(0);
		add_crlf();
		rx_hold_cycles = 300;
		send_body();
	endtask

	task automatic test_noise();
		logic [7:0] b;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (int i = 0; i < 200; i++) begin
			case ($urandom_range(0, 9))
				0:       b = CH_CR;
				1:       b = CH_LF;
				2:       b = CH_ZERO;
				3:       b = $urandom_range(0, 1) ? CH_X_LO : CH_X_UP;
				4:       b = hex_char(4'($urandom_range(0, 15)));
				5:       b = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
				6:       b = $urandom_range(0, 1) ? 8'h2B : 8'h2D;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_word(b, i == 199 || $urandom_range(0, 24) == 0);
		end
	endtask

	task automatic test_steady_stream();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		while (items_sent < ITEM_TARGET) begin
			build_body();
			send_body();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		body_ch.valid   = 1'b0;
		body_ch.in_byte = 8'h00;
		body_ch.in_last = 1'b0;
		clear_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_cases();
		test_random_bodies();
		test_output_backpressure();
		test_noise();
		test_steady_stream();

		body_ch.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0 && decoded_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
